// ----- rtl/tspi_pkg.sv -----
// ----------------------------------------------------------------------------
// tspi_pkg
// Shared constants and types for the triangle slice plane intersect unit.
// ----------------------------------------------------------------------------
package tspi_pkg;

	localparam int COORD_BITS_DEF = 32;
	localparam int TOL_BITS       = 16;
	localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd655;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_FACET = 2'd1,
		KIND_SEG   = 2'd2
	} kind_t;

endpackage

// ----- rtl/triangle_slice_plane_intersect_unit.sv -----
// ----------------------------------------------------------------------------
// triangle_slice_plane_intersect_unit
// Slices one triangle per word against a horizontal plane.
// ----------------------------------------------------------------------------
// Takes one triangle word per clock while s_tready is high and returns one
// result word per triangle, in order. The edge point dividers for head and
// tail x/y set the pipeline depth; they resolve one quotient bit per stage.
// Throughput is one word per cycle whenever the output side takes words.
// All stages advance together: a stalled output word freezes the whole
// pipe, so nothing is lost or repeated, while empty stages keep filling as
// long as the output register is free or being read.
// Vertices are sorted by descending z, tested against slice_z with the
// tolerance register (Q0.16, reset 655), and the segment end points are
// found by exact interpolation with saturation. For "no intersection" and
// "facet in plane" all coordinates read as zero. The tolerance may be
// written at any idle time and takes effect for the next triangle.

module triangle_slice_plane_intersect_unit import tspi_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// config: tolerance register
	input  logic                                  cfg_we,
	input  logic [TOL_BITS-1:0]                   cfg_wdata,
	// triangle words
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z, slice_z
	input  logic [((10*COORD_BITS+7)/8)*8-1:0]    s_tdata,
	// result words
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// head_x, head_y, tail_x, tail_y
	output logic [((4*COORD_BITS+7)/8)*8-1:0]     m_tdata,
	// kind
	output logic [1:0]                            m_tuser
);

	localparam int CW    = COORD_BITS;
	localparam int OUT_W = ((4*CW+7)/8)*8;
	localparam int ES    = CW + 5;        // edge unit depth
	localparam int NS    = ES + 3;        // sort (2) + classify (1) + edge

	logic en;
	logic [NS-1:0] vld_q;
	logic [TOL_BITS-1:0] tol_q;

	// single pipeline enable: move whenever the output register is free or being read
	assign en       = !vld_q[NS-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			tol_q <= TOL_RESET;
		end else begin
			if (cfg_we) begin
				tol_q <= cfg_wdata;
			end
			if (en) begin
				vld_q <= {vld_q[NS-2:0], s_tvalid};
			end
		end
	end

	// unpack triangle word
	logic signed [CW-1:0] vx [3], vy [3], vz [3];
	logic signed [CW-1:0] h;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vx[i] = s_tdata[(3*i)*CW +: CW];
			vy[i] = s_tdata[(3*i+1)*CW +: CW];
			vz[i] = s_tdata[(3*i+2)*CW +: CW];
		end
		h = s_tdata[9*CW +: CW];
	end

	// stages 1-2: sort and plane distances
	logic signed [CW-1:0] px [3], py [3];
	logic signed [CW:0]   pd [3];

	tspi_sort #(.COORD_BITS(COORD_BITS)) u_sort (
		.clk (clk),
		.en  (en),
		.vx  (vx),
		.vy  (vy),
		.vz  (vz),
		.h   (h),
		.px  (px),
		.py  (py),
		.pd  (pd)
	);

	// stage 3: case selection and edge pick
	kind_t                kind_s3;
	logic signed [CW-1:0] ax_s3 [2], bx_s3 [2], ay_s3 [2], by_s3 [2];
	logic signed [CW:0]   da_s3 [2], db_s3 [2];
	logic                 pass_s3 [2];

	tspi_classify #(.COORD_BITS(COORD_BITS)) u_classify (
		.clk     (clk),
		.en      (en),
		.tol     (tol_q),
		.px      (px),
		.py      (py),
		.pd      (pd),
		.kind_s3 (kind_s3),
		.ax_s3   (ax_s3),
		.bx_s3   (bx_s3),
		.ay_s3   (ay_s3),
		.by_s3   (by_s3),
		.da_s3   (da_s3),
		.db_s3   (db_s3),
		.pass_s3 (pass_s3)
	);

	// edge point units: head x/y and tail x/y
	logic signed [CW-1:0] pt_x [2], pt_y [2];

	for (genvar e = 0; e < 2; e++) begin : g_pt
		tspi_edge #(.COORD_BITS(COORD_BITS)) u_edge_x (
			.clk  (clk),
			.en   (en),
			.ca   (ax_s3[e]),
			.cb   (bx_s3[e]),
			.da   (da_s3[e]),
			.db   (db_s3[e]),
			.pass (pass_s3[e]),
			.pt_q (pt_x[e])
		);
		tspi_edge #(.COORD_BITS(COORD_BITS)) u_edge_y (
			.clk  (clk),
			.en   (en),
			.ca   (ay_s3[e]),
			.cb   (by_s3[e]),
			.da   (da_s3[e]),
			.db   (db_s3[e]),
			.pass (pass_s3[e]),
			.pt_q (pt_y[e])
		);
	end

	// kind rides alongside the edge units
	kind_t kind_q [ES];

	always_ff @(posedge clk) begin
		if (en) begin
			kind_q[0] <= kind_s3;
			for (int i = 1; i < ES; i++) begin
				kind_q[i] <= kind_q[i-1];
			end
		end
	end

	assign m_tuser = kind_q[ES-1];
	assign m_tdata = OUT_W'({pt_y[1], pt_x[1], pt_y[0], pt_x[0]});

	// checks
	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != KIND_SEG) |-> m_tdata == '0)
		else $error("non-segment result carries coordinates");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == KIND_NONE) || (m_tuser == KIND_FACET)
			|| (m_tuser == KIND_SEG))
		else $error("illegal kind code at output");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_q[0])
		else $error("accepted word not in first stage");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline moved while stalled");

endmodule

// ----- rtl/tspi_sort.sv -----
// ----------------------------------------------------------------------------
// tspi_sort
// Two stage vertex sort by descending z, plus plane distances d = z - h.
// ----------------------------------------------------------------------------
module tspi_sort import tspi_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [COORD_BITS-1:0] vx [3],
	input  logic signed [COORD_BITS-1:0] vy [3],
	input  logic signed [COORD_BITS-1:0] vz [3],
	input  logic signed [COORD_BITS-1:0] h,
	output logic signed [COORD_BITS-1:0] px [3],
	output logic signed [COORD_BITS-1:0] py [3],
	output logic signed [COORD_BITS:0]   pd [3]
);

	localparam int CW = COORD_BITS;
	localparam int DW = CW + 1;

	logic signed [CW-1:0] ax [3], ay [3], az [3];
	logic signed [CW-1:0] bx [3], by [3], bz [3];
	logic signed [CW-1:0] x_s1 [3], y_s1 [3], z_s1 [3];
	logic signed [CW-1:0] h_s1;

	// compare-and-swap 1-2 then 1-3; swap only on strictly smaller
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ax[i] = vx[i];
			ay[i] = vy[i];
			az[i] = vz[i];
		end
		if (vz[0] < vz[1]) begin
			ax[0] = vx[1]; ay[0] = vy[1]; az[0] = vz[1];
			ax[1] = vx[0]; ay[1] = vy[0]; az[1] = vz[0];
		end
		for (int i = 0; i < 3; i++) begin
			bx[i] = ax[i];
			by[i] = ay[i];
			bz[i] = az[i];
		end
		if (az[0] < az[2]) begin
			bx[0] = ax[2]; by[0] = ay[2]; bz[0] = az[2];
			bx[2] = ax[0]; by[2] = ay[0]; bz[2] = az[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= bx;
			y_s1 <= by;
			z_s1 <= bz;
			h_s1 <= h;
		end
	end

	// compare-and-swap 2-3, then distances to the plane
	logic swap23;
	assign swap23 = z_s1[1] < z_s1[2];

	always_ff @(posedge clk) begin
		if (en) begin
			px[0] <= x_s1[0];
			py[0] <= y_s1[0];
			pd[0] <= DW'(z_s1[0]) - DW'(h_s1);
			px[1] <= swap23 ? x_s1[2] : x_s1[1];
			py[1] <= swap23 ? y_s1[2] : y_s1[1];
			pd[1] <= (swap23 ? DW'(z_s1[2]) : DW'(z_s1[1])) - DW'(h_s1);
			px[2] <= swap23 ? x_s1[1] : x_s1[2];
			py[2] <= swap23 ? y_s1[1] : y_s1[2];
			pd[2] <= (swap23 ? DW'(z_s1[1]) : DW'(z_s1[2])) - DW'(h_s1);
		end
	end

endmodule

// ----- rtl/tspi_classify.sv -----
// ----------------------------------------------------------------------------
// tspi_classify
// Classifies the sorted triangle against the plane and picks the edges
// (or fixed points) that feed the head and tail point units.
// ----------------------------------------------------------------------------
module tspi_classify import tspi_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [TOL_BITS-1:0]          tol,
	input  logic signed [COORD_BITS-1:0] px [3],
	input  logic signed [COORD_BITS-1:0] py [3],
	input  logic signed [COORD_BITS:0]   pd [3],
	output kind_t                        kind_s3,
	// per point: [0] head, [1] tail
	output logic signed [COORD_BITS-1:0] ax_s3 [2],
	output logic signed [COORD_BITS-1:0] bx_s3 [2],
	output logic signed [COORD_BITS-1:0] ay_s3 [2],
	output logic signed [COORD_BITS-1:0] by_s3 [2],
	output logic signed [COORD_BITS:0]   da_s3 [2],
	output logic signed [COORD_BITS:0]   db_s3 [2],
	output logic                         pass_s3 [2]
);

	localparam int CW = COORD_BITS;
	localparam int DW = CW + 1;

	logic signed [DW-1:0] tl, ntl;
	logic on1, on2, on3;
	kind_t kind;
	logic signed [CW-1:0] ax [2], bx [2], ay [2], by [2];
	logic signed [DW-1:0] da [2], db [2];
	logic pass [2];

	always_comb begin
		tl  = DW'(tol);
		ntl = -tl;
		on1 = (pd[0] <= tl) && (pd[0] >= ntl);
		on2 = (pd[1] <= tl) && (pd[1] >= ntl);
		on3 = (pd[2] <= tl) && (pd[2] >= ntl);
		kind = KIND_SEG;
		for (int i = 0; i < 2; i++) begin
			ax[i]   = '0;
			bx[i]   = '0;
			ay[i]   = '0;
			by[i]   = '0;
			da[i]   = '0;
			db[i]   = '0;
			pass[i] = 1'b1;
		end
		if (on1 && on3) begin
			kind = KIND_FACET;
		end else if (on1 && on2) begin
			ax[0] = px[0]; ay[0] = py[0];
			ax[1] = px[1]; ay[1] = py[1];
		end else if (on2 && on3) begin
			ax[0] = px[1]; ay[0] = py[1];
			ax[1] = px[2]; ay[1] = py[2];
		end else if (on2) begin
			ax[0] = px[1]; ay[0] = py[1];
			ax[1] = px[0]; bx[1] = px[2]; ay[1] = py[0]; by[1] = py[2];
			da[1] = pd[0]; db[1] = pd[2]; pass[1] = 1'b0;
		end else if (pd[1] > tl && pd[2] < ntl) begin
			ax[0] = px[0]; bx[0] = px[2]; ay[0] = py[0]; by[0] = py[2];
			da[0] = pd[0]; db[0] = pd[2]; pass[0] = 1'b0;
			ax[1] = px[1]; bx[1] = px[2]; ay[1] = py[1]; by[1] = py[2];
			da[1] = pd[1]; db[1] = pd[2]; pass[1] = 1'b0;
		end else if (pd[0] > tl && pd[1] < ntl) begin
			ax[0] = px[0]; bx[0] = px[1]; ay[0] = py[0]; by[0] = py[1];
			da[0] = pd[0]; db[0] = pd[1]; pass[0] = 1'b0;
			ax[1] = px[2]; bx[1] = px[0]; ay[1] = py[2]; by[1] = py[0];
			da[1] = pd[2]; db[1] = pd[0]; pass[1] = 1'b0;
		end else begin
			kind = KIND_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s3 <= kind;
			ax_s3   <= ax;
			bx_s3   <= bx;
			ay_s3   <= ay;
			by_s3   <= by;
			da_s3   <= da;
			db_s3   <= db;
			pass_s3 <= pass;
		end
	end

endmodule

// ----- rtl/tspi_edge.sv -----
// ----------------------------------------------------------------------------
// tspi_edge
// Pipelined edge point: (cb*da - ca*db) / (da - db), truncated, saturated.
// One quotient bit per stage. A pass point returns ca unchanged.
// ----------------------------------------------------------------------------
module tspi_edge import tspi_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [COORD_BITS-1:0] ca,
	input  logic signed [COORD_BITS-1:0] cb,
	input  logic signed [COORD_BITS:0]   da,
	input  logic signed [COORD_BITS:0]   db,
	input  logic                         pass,
	output logic signed [COORD_BITS-1:0] pt_q
);

	localparam int CW = COORD_BITS;
	localparam int DW = CW + 1;
	localparam int PW = 2 * CW + 1;
	localparam int NW = 2 * CW + 2;
	localparam int HW = NW - CW;

	// s1: products
	logic signed [PW-1:0] pa_s1, pb_s1;
	logic signed [DW-1:0] den_s1;
	logic signed [CW-1:0] ca_s1;
	logic                 pass_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1   <= PW'(cb) * PW'(da);
			pb_s1   <= PW'(ca) * PW'(db);
			den_s1  <= da - db;
			ca_s1   <= ca;
			pass_s1 <= pass;
		end
	end

	// s2: numerator; flat edge folds into pass
	logic signed [NW-1:0] num_s2;
	logic signed [DW-1:0] den_s2;
	logic signed [CW-1:0] ca_s2;
	logic                 pass_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2  <= NW'(pa_s1) - NW'(pb_s1);
			den_s2  <= den_s1;
			ca_s2   <= ca_s1;
			pass_s2 <= pass_s1 || (den_s1 == '0);
		end
	end

	// s3: magnitudes and result sign
	logic [NW-1:0]        mag_s3;
	logic [DW-1:0]        ud_s3;
	logic                 neg_s3;
	logic signed [CW-1:0] ca_s3;
	logic                 pass_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s3  <= num_s2[NW-1] ? NW'(-num_s2) : NW'(num_s2);
			ud_s3   <= den_s2[DW-1] ? DW'(-den_s2) : DW'(den_s2);
			neg_s3  <= num_s2[NW-1] ^ den_s2[DW-1];
			ca_s3   <= ca_s2;
			pass_s3 <= pass_s2;
		end
	end

	// divider: entry [0] is the setup stage, [j+1] after quotient bit j
	logic [DW-1:0]        rem_s  [CW+1];
	logic [CW-1:0]        low_s  [CW+1];
	logic [CW-1:0]        quo_s  [CW+1];
	logic [DW-1:0]        ud_s   [CW+1];
	logic                 ovf_s  [CW+1];
	logic                 neg_s  [CW+1];
	logic signed [CW-1:0] ca_sd  [CW+1];
	logic                 pass_sd [CW+1];

	// quotient would reach 2^CW when the upper part already holds a divisor
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]   <= mag_s3[DW-1+CW:CW];
			low_s[0]   <= mag_s3[CW-1:0];
			quo_s[0]   <= '0;
			ud_s[0]    <= ud_s3;
			ovf_s[0]   <= HW'(mag_s3[NW-1:CW]) >= HW'(ud_s3);
			neg_s[0]   <= neg_s3;
			ca_sd[0]   <= ca_s3;
			pass_sd[0] <= pass_s3;
		end
	end

	for (genvar j = 0; j < CW; j++) begin : g_div
		logic [DW:0] trial;
		logic        fit;
		assign trial = {rem_s[j], low_s[j][CW-1]};
		assign fit   = trial >= (DW+1)'(ud_s[j]);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]   <= fit ? DW'(trial - (DW+1)'(ud_s[j])) : DW'(trial);
				low_s[j+1]   <= low_s[j] << 1;
				quo_s[j+1]   <= {quo_s[j][CW-2:0], fit};
				ud_s[j+1]    <= ud_s[j];
				ovf_s[j+1]   <= ovf_s[j];
				neg_s[j+1]   <= neg_s[j];
				ca_sd[j+1]   <= ca_sd[j];
				pass_sd[j+1] <= pass_sd[j];
			end
		end
	end

	// saturation and pass select
	logic [CW-1:0] q;
	logic          big;
	assign q = quo_s[CW];
	always_comb begin
		if (neg_s[CW]) begin
			big = ovf_s[CW] || (q[CW-1] && (q[CW-2:0] != '0));
		end else begin
			big = ovf_s[CW] || q[CW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (pass_sd[CW]) begin
				pt_q <= ca_sd[CW];
			end else if (big) begin
				pt_q <= neg_s[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
			end else begin
				pt_q <= neg_s[CW] ? -$signed(q) : $signed(q);
			end
		end
	end

endmodule

// ----- bench/triangle_slice_plane_intersect_unit_test.sv -----
// ----------------------------------------------------------------------------
// triangle_slice_plane_intersect_unit_test
// Self-checking bench for the triangle slice plane intersect unit.
// ----------------------------------------------------------------------------
// Streams triangle words into the unit with bursty input and a stalling
// output side. A scoreboard predicts each result word (sort, classify,
// interpolate with saturation) and checks the results in order. Directed
// triangles cover each classification case, flat edges and saturation.
// Random triangles are then built around the slice plane under several
// tolerance settings, including both extremes.
// ----------------------------------------------------------------------------
module triangle_slice_plane_intersect_unit_test;
	import tspi_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = 32;
	localparam int IN_W = 320;
	localparam int OUT_W = 128;
	localparam int LATENCY = CB + 8;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int LONG_HOLD = 300;

	typedef logic signed [CB-1:0] coord_t;

	typedef struct packed {
		kind_t  kind;
		coord_t head_x;
		coord_t head_y;
		coord_t tail_x;
		coord_t tail_y;
	} slice_t;

	// Result predictor and in-order store of expected slices.
	class slice_scoreboard;
		logic [TOL_BITS-1:0] tol;
		slice_t pending[$];
		int mismatches;

		function new();
			tol = TOL_RESET;
			pending = {};
			mismatches = 0;
		endfunction

		// exact interpolation on edge A-B at height h, truncated, saturated
		function coord_t edge_point(coord_t ca, coord_t cb, coord_t za, coord_t zb,
				coord_t h);
			logic signed [127:0] num, den, q;
			if (za == zb)
				return ca;
			num = 128'(h) * (128'(ca) - 128'(cb)) + 128'(cb) * 128'(za)
				- 128'(ca) * 128'(zb);
			den = 128'(za) - 128'(zb);
			q = num / den;
			if (q > 128'sh7fffffff)
				return 32'sh7fffffff;
			if (q < -128'sh80000000)
				return 32'sh80000000;
			return coord_t'(q);
		endfunction

		function void note_triangle(logic [IN_W-1:0] w);
			coord_t p[3][3];
			coord_t t;
			coord_t h;
			logic signed [35:0] d1, d2, d3, tl;
			bit on1, on2, on3;
			slice_t r;
			for (int v = 0; v < 3; v++)
				for (int k = 0; k < 3; k++)
					p[v][k] = w[(v*3+k)*CB +: CB];
			h = w[9*CB +: CB];
			// compare-and-swap network, ties keep order
			if (p[0][2] < p[1][2])
				for (int k = 0; k < 3; k++) begin
					t = p[0][k]; p[0][k] = p[1][k]; p[1][k] = t;
				end
			if (p[0][2] < p[2][2])
				for (int k = 0; k < 3; k++) begin
					t = p[0][k]; p[0][k] = p[2][k]; p[2][k] = t;
				end
			if (p[1][2] < p[2][2])
				for (int k = 0; k < 3; k++) begin
					t = p[1][k]; p[1][k] = p[2][k]; p[2][k] = t;
				end
			d1 = 36'(p[0][2]) - 36'(h);
			d2 = 36'(p[1][2]) - 36'(h);
			d3 = 36'(p[2][2]) - 36'(h);
			tl = 36'($signed({1'b0, tol}));
			on1 = d1 <= tl && d1 >= -tl;
			on2 = d2 <= tl && d2 >= -tl;
			on3 = d3 <= tl && d3 >= -tl;
			r = '0;
			r.kind = KIND_SEG;
			if (on1 && on3) begin
				r.kind = KIND_FACET;
			end else if (on1 && on2) begin
				r.head_x = p[0][0]; r.head_y = p[0][1];
				r.tail_x = p[1][0]; r.tail_y = p[1][1];
			end else if (on2 && on3) begin
				r.head_x = p[1][0]; r.head_y = p[1][1];
				r.tail_x = p[2][0]; r.tail_y = p[2][1];
			end else if (on2) begin
				r.head_x = p[1][0]; r.head_y = p[1][1];
				r.tail_x = edge_point(p[0][0], p[2][0], p[0][2], p[2][2], h);
				r.tail_y = edge_point(p[0][1], p[2][1], p[0][2], p[2][2], h);
			end else if (d2 > tl && d3 < -tl) begin
				r.head_x = edge_point(p[0][0], p[2][0], p[0][2], p[2][2], h);
				r.head_y = edge_point(p[0][1], p[2][1], p[0][2], p[2][2], h);
				r.tail_x = edge_point(p[1][0], p[2][0], p[1][2], p[2][2], h);
				r.tail_y = edge_point(p[1][1], p[2][1], p[1][2], p[2][2], h);
			end else if (d1 > tl && d2 < -tl) begin
				r.head_x = edge_point(p[0][0], p[1][0], p[0][2], p[1][2], h);
				r.head_y = edge_point(p[0][1], p[1][1], p[0][2], p[1][2], h);
				r.tail_x = edge_point(p[2][0], p[0][0], p[2][2], p[0][2], h);
				r.tail_y = edge_point(p[2][1], p[0][1], p[2][2], p[0][2], h);
			end else begin
				r.kind = KIND_NONE;
			end
			pending.insert(pending.size(), r);
		endfunction

		function void check_result(logic [1:0] user, logic [OUT_W-1:0] data);
			slice_t got, want;
			got.kind = kind_t'(user);
			got.head_x = data[0 +: CB];
			got.head_y = data[CB +: CB];
			got.tail_x = data[2*CB +: CB];
			got.tail_y = data[3*CB +: CB];
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word kind=%0d", user);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: exp kind=%0d h=(%0d,%0d) t=(%0d,%0d)",
						want.kind, want.head_x, want.head_y, want.tail_x, want.tail_y);
					$display("          got kind=%0d h=(%0d,%0d) t=(%0d,%0d)",
						got.kind, got.head_x, got.head_y, got.tail_x, got.tail_y);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [TOL_BITS-1:0] cfg_wdata;
	logic s_tvalid;
	logic s_tready;
	logic [IN_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic [1:0] m_tuser;

	slice_scoreboard sb;
	bit stim_done;
	bit hold_req;       // asks the receiver for a long hold-off
	int idle_cycles = 0;
	int burst_left;

	triangle_slice_plane_intersect_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result checking at each accepted output word
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata);
	end

	// watchdog on cycles with no word moving either way
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// receiver: own stall pattern, plus one long hold-off on request
	initial begin : receiver
		int mode;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(1, 40)) begin
				@(posedge clk);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ($urandom_range(0, 1) != 0);
					default: m_tready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	// offer one triangle word; bursts with random gaps between them
	task automatic send_triangle(logic [IN_W-1:0] w);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 30);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_triangle(w);
		burst_left--;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic set_tolerance(logic [TOL_BITS-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.tol = v;
	endtask

	function automatic logic [IN_W-1:0] pack_tri(coord_t ax, coord_t ay, coord_t az,
			coord_t bx, coord_t by, coord_t bz, coord_t cx, coord_t cy, coord_t cz,
			coord_t h);
		return {h, cz, cy, cx, bz, by, bx, az, ay, ax};
	endfunction

	// z near the plane: on it, just inside/outside the band, or far off
	function automatic coord_t z_near(coord_t h, int tol);
		longint z;
		case ($urandom_range(0, 5))
			0: z = longint'(h) + longint'($urandom_range(0, 2*tol)) - tol;
			1: z = longint'(h) + tol + longint'($urandom_range(0, 2));
			2: z = longint'(h) - tol - longint'($urandom_range(0, 2));
			3: z = longint'(h) + longint'($urandom_range(0, 1 << 22));
			4: z = longint'(h) - longint'($urandom_range(0, 1 << 22));
			default: z = $signed($urandom());
		endcase
		if (z > 64'sh7fffffff) z = 64'sh7fffffff;
		if (z < -64'sh80000000) z = -64'sh80000000;
		return coord_t'(z);
	endfunction

	function automatic coord_t rnd_xy();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
		endcase
	endfunction

	function automatic logic [IN_W-1:0] rnd_triangle(int tol);
		coord_t h;
		if ($urandom_range(0, 9) == 0)
			return {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
		h = $urandom_range(0, 3) == 0 ? coord_t'($urandom())
			: coord_t'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
		return pack_tri(rnd_xy(), rnd_xy(), z_near(h, tol), rnd_xy(), rnd_xy(),
			z_near(h, tol), rnd_xy(), rnd_xy(), z_near(h, tol), h);
	endfunction

	initial begin : stimulus
		int tols[6];
		coord_t mx, mn;
		sb = new();
		stim_done = 0;
		hold_req = 0;
		burst_left = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		mx = 32'sh7fffffff;
		mn = 32'sh80000000;

		// directed: reset tolerance 655
		send_triangle(pack_tri(1, 2, 0, 3, 4, 100, 5, 6, -100, 0));            // facet
		send_triangle(pack_tri(1, 2, 0, 3, 4, 10, 5, 6, -90000, 0));           // edge top
		send_triangle(pack_tri(7, 8, 90000, 3, 4, 10, 5, 6, 0, 0));            // edge bottom
		send_triangle(pack_tri(0, 0, 65536, 9, 9, 0, 65536, 131072, -65536, 0)); // mid touch
		send_triangle(pack_tri(0, 0, 65536, 5, 5, 32768, 65536, 65536, -65536, 0));
		send_triangle(pack_tri(0, 0, 65536, 5, 5, -32768, 65536, 65536, -65536, 0));
		send_triangle(pack_tri(1, 1, 0, 2, 2, -70000, 3, 3, -80000, 0));       // lone top
		send_triangle(pack_tri(1, 1, 90000, 2, 2, 70000, 3, 3, 0, 0));         // lone bottom
		send_triangle(pack_tri(1, 1, 90000, 2, 2, 80000, 3, 3, 70000, 0));     // all above
		send_triangle(pack_tri(1, 1, 5, 2, 2, 5, 3, 3, 5, 5));                 // equal z
		send_triangle(pack_tri(mx, mn, mx, mn, mx, mn, 0, 0, 0, 0));            // wide crossing
		send_triangle(pack_tri(mx, mx, mx, mn, mn, mn, mx, mn, mn + 1, mx - 1)); // saturation
		send_triangle(pack_tri(mn, mx, 2, mx, mn, 1, mn, mn, mn, 0));
		send_triangle(pack_tri('1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
		send_triangle(pack_tri(mx, mx, 655, 1, 1, -655, 2, 2, 656, 0));
		send_triangle(pack_tri(0, 0, 656, 1, 1, -656, 2, 2, 100000, 0));
		drain();

		// random phases over a spread of tolerances, extremes included
		tols = '{0, 65535, 655, 1, 32768, 300};
		foreach (tols[i]) begin
			set_tolerance(TOL_BITS'(tols[i]));
			for (int n = 0; n < 340; n++) begin
				if (i == 2 && n == 100) begin
					hold_req = 1;     // receiver parks while words keep coming
					burst_left = 400;
				end
				send_triangle(rnd_triangle(tols[i]));
			end
			drain();
		end
		stim_done = 1;

		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
